// File: sv/blifo_pkg.sv
`default_nettype none

package blifo_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int POP_CNT_W     = 6;
    localparam int S_TDATA_W     = 40;
    localparam int S_TUSER_W     = OP_W;
    localparam int M_TDATA_W     = DATA_W;
    localparam int M_TUSER_W     = 2;
    localparam int MAX_POP       = 32;
    localparam int PEEK_SPAN     = 3;
    localparam int BOTTOM_IDX    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_PEEK_TOP = 3'd2,
        OP_POP_N    = 3'd3,
        OP_PEEK_BOT = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_READ   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

endpackage

`default_nettype wire

// File: sv/blifo_ram.sv
`default_nettype none

module blifo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/bounded_lifo_stack_core.sv
// Bounded LIFO stack of signed 32-bit words, DEPTH entries deep.
// Input channel s_*: tuser carries the opcode (push, pop, peek third from top,
// pop n, peek third from bottom); tdata carries push_value and pop_count.
// Result channel m_*: tdata carries the popped or peeked word (zero when none),
// tuser carries status and data_valid, tlast marks the final result of an item.
// Every input item yields at least one result; pop n yields one per word,
// newest first. Errors yield one result with status set and leave the stack
// unchanged.
// Push and error cases finish without a RAM read. Pop and both peeks read one
// word through the registered read port of the stack RAM; pop n reads one word
// per cycle, but only while the output register is free to take the word.
// Every result is registered in the output register before it is offered.
// Reset clears the held-entry count and the control state; the RAM is not
// cleared, since only entries written by a push are ever read.
// When the receiver stalls, the finished result waits in the output register;
// one more item is taken and its result parked until the output frees up.
`default_nettype none

module bounded_lifo_stack_core
    import blifo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // push_value[31:0], pop_count[37:32]
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // opcode[2:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // data_value[31:0]
    output logic      [M_TUSER_W-1:0] m_tuser,  // status[0], data_valid[1]
    output logic                      m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = (CW > POP_CNT_W) ? CW : POP_CNT_W;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [POP_CNT_W-1:0]   rem_reg, rem_next;
    logic                   pend_reg, pend_next;

    logic                   m_tvalid_reg;
    logic                   m_status_reg;
    logic                   m_dvalid_reg;
    logic                   m_last_reg;
    logic [DATA_W-1:0]      m_data_reg;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic                   out_status;
    logic                   out_dvalid;
    logic                   out_last;

    logic                   ram_we;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [DATA_W-1:0]      ram_rdata;
    logic [CW-1:0]          cnt_dec;

    op_t                    op;
    logic [DATA_W-1:0]      push_value;
    logic [POP_CNT_W-1:0]   pop_count;
    logic                   imm;
    logic                   err;

    assign op         = op_t'(s_tuser);
    assign push_value = s_tdata[DATA_W-1:0];
    assign pop_count  = s_tdata[DATA_W+POP_CNT_W-1:DATA_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_dec  = cnt_reg - CW'(1);

    blifo_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(cnt_reg[AW-1:0]),
        .wdata(push_value),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        pend_next  = pend_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = cnt_dec[AW-1:0];
        out_load   = 1'b0;
        out_status = 1'b0;
        out_dvalid = 1'b0;
        out_last   = 1'b1;
        imm        = 1'b0;
        err        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_PUSH: begin
                            imm = 1'b1;
                            if (cnt_reg == CW'(DEPTH)) begin
                                err = 1'b1;
                            end else begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (cnt_reg == '0) begin
                                imm = 1'b1;
                                err = 1'b1;
                            end else begin
                                ram_re     = 1'b1;
                                cnt_next   = cnt_dec;
                                rem_next   = POP_CNT_W'(1);
                                state_next = ST_READ;
                            end
                        end
                        OP_PEEK_TOP: begin
                            if (cnt_reg < CW'(PEEK_SPAN)) begin
                                imm = 1'b1;
                                err = 1'b1;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(cnt_reg - CW'(PEEK_SPAN));
                                rem_next   = POP_CNT_W'(1);
                                state_next = ST_READ;
                            end
                        end
                        OP_POP_N: begin
                            if (NW'(pop_count) > NW'(cnt_reg) ||
                                pop_count > POP_CNT_W'(MAX_POP)) begin
                                imm = 1'b1;
                                err = 1'b1;
                            end else if (pop_count == '0) begin
                                imm = 1'b1;
                            end else begin
                                ram_re     = 1'b1;
                                cnt_next   = cnt_dec;
                                rem_next   = pop_count;
                                state_next = ST_READ;
                            end
                        end
                        OP_PEEK_BOT: begin
                            if (cnt_reg < CW'(PEEK_SPAN)) begin
                                imm = 1'b1;
                                err = 1'b1;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(BOTTOM_IDX);
                                rem_next   = POP_CNT_W'(1);
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            imm = 1'b1;
                            err = 1'b1;
                        end
                    endcase
                    if (imm) begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            out_status = err;
                        end else begin
                            pend_next  = err;
                            state_next = ST_RESULT;
                        end
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_dvalid = 1'b1;
                    out_last   = (rem_reg == POP_CNT_W'(1));
                    if (rem_reg == POP_CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        ram_re   = 1'b1;
                        cnt_next = cnt_dec;
                        rem_next = rem_reg - POP_CNT_W'(1);
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = pend_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        pend_reg <= pend_next;
        if (out_load) begin
            m_status_reg <= out_status;
            m_dvalid_reg <= out_dvalid;
            m_last_reg   <= out_last;
            m_data_reg   <= out_dvalid ? ram_rdata : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_dvalid_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        NW'(cnt_reg) <= NW'(DEPTH))
        else $error("held-entry count above depth");

    a_read_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (rem_reg != '0))
        else $error("read state with no word left to emit");

    a_word_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_dvalid_reg) |-> !m_status_reg)
        else $error("word result flagged as error");

    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && out_free && rem_reg != POP_CNT_W'(1))
            |=> (cnt_reg == $past(cnt_dec)))
        else $error("pop n did not advance the count");

endmodule

`default_nettype wire

// File: test/bounded_lifo_stack_core_test.sv
`default_nettype none

module bounded_lifo_stack_core_test;
    import blifo_pkg::*;

    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_ITEMS = 160;

    typedef struct {
        logic        pause;
        logic [2:0]  op;
        logic [31:0] word;
        logic [5:0]  count;
    } stack_cmd_t;

    typedef struct {
        logic        status;
        logic [31:0] word;
        logic        word_ok;
        logic        last;
    } stack_reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;  // push_value[31:0], pop_count[37:32]
    logic [S_TUSER_W-1:0] s_tuser = '0;  // opcode[2:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;       // data_value[31:0]
    logic [M_TUSER_W-1:0] m_tuser;       // status[0], data_valid[1]
    logic                 m_tlast;

    stack_cmd_t   pending_cmds[$];
    stack_reply_t due_replies[$];
    logic [31:0]  stack_words[DEPTH_DEF];
    int           held_cnt;
    int           plan_depth;
    int           gap_left;
    int           stall_left;
    bit           draining;
    bit           src_calm;
    bit           sink_calm;
    int           mismatches;
    int           cycles;

    bounded_lifo_stack_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 2);
        end else if (r < 92) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic add_cmd(input logic [2:0] op, input logic [31:0] word,
                           input logic [5:0] count);
        stack_cmd_t c;
        c.pause = 1'b0;
        c.op    = op;
        c.word  = word;
        c.count = count;
        pending_cmds.push_back(c);
        case (op)
            OP_PUSH: if (plan_depth < DEPTH_DEF) plan_depth++;
            OP_POP:  if (plan_depth > 0) plan_depth--;
            OP_POP_N: begin
                if (count <= plan_depth && count <= MAX_POP) plan_depth -= count;
            end
            default: ;
        endcase
    endtask

    task automatic add_pause();
        stack_cmd_t c;
        c.pause = 1'b1;
        c.op    = OP_PUSH;
        c.word  = '0;
        c.count = '0;
        pending_cmds.push_back(c);
    endtask

    task automatic expect_reply(input logic status, input logic [31:0] word,
                                input logic word_ok, input logic last);
        stack_reply_t e;
        e.status  = status;
        e.word    = word;
        e.word_ok = word_ok;
        e.last    = last;
        due_replies.push_back(e);
    endtask

    task automatic model_stack_op(input logic [2:0] op, input logic [31:0] word,
                                  input logic [5:0] count);
        int n;
        n = count;
        case (op)
            OP_PUSH: begin
                if (held_cnt >= DEPTH_DEF) begin
                    expect_reply(1'b1, '0, 1'b0, 1'b1);
                end else begin
                    stack_words[held_cnt] = word;
                    held_cnt++;
                    expect_reply(1'b0, '0, 1'b0, 1'b1);
                end
            end
            OP_POP: begin
                if (held_cnt == 0) begin
                    expect_reply(1'b1, '0, 1'b0, 1'b1);
                end else begin
                    held_cnt--;
                    expect_reply(1'b0, stack_words[held_cnt], 1'b1, 1'b1);
                end
            end
            OP_PEEK_TOP: begin
                if (held_cnt < PEEK_SPAN) begin
                    expect_reply(1'b1, '0, 1'b0, 1'b1);
                end else begin
                    expect_reply(1'b0, stack_words[held_cnt-PEEK_SPAN], 1'b1, 1'b1);
                end
            end
            OP_PEEK_BOT: begin
                if (held_cnt < PEEK_SPAN) begin
                    expect_reply(1'b1, '0, 1'b0, 1'b1);
                end else begin
                    expect_reply(1'b0, stack_words[BOTTOM_IDX], 1'b1, 1'b1);
                end
            end
            OP_POP_N: begin
                if (n > held_cnt || n > MAX_POP) begin
                    expect_reply(1'b1, '0, 1'b0, 1'b1);
                end else if (n == 0) begin
                    expect_reply(1'b0, '0, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        held_cnt--;
                        expect_reply(1'b0, stack_words[held_cnt], 1'b1, i == n - 1);
                    end
                end
            end
            default: expect_reply(1'b1, '0, 1'b0, 1'b1);
        endcase
    endtask

    // driver
    always @(posedge aclk) begin
        stack_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
            draining = 1'b0;
        end else begin
            if ($urandom_range(0, 299) == 0) src_calm = !src_calm;
            if (s_tvalid && s_tready) begin
                gap_left = (src_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
            end
            if (!s_tvalid || s_tready) begin
                if (draining) begin
                    if (due_replies.size() == 0) draining = 1'b0;
                    s_tvalid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    if (c.pause) begin
                        draining = 1'b1;
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tvalid <= 1'b1;
                        s_tdata  <= {2'b00, c.count, c.word};
                        s_tuser  <= c.op;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: check results, then record accepted items
    always @(posedge aclk) begin
        stack_reply_t e;
        if (!aresetn) begin
            held_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: status %0b data %0d valid %0b last %0b",
                                 m_tuser[0], $signed(m_tdata), m_tuser[1], m_tlast);
                    end
                end else begin
                    e = due_replies.pop_front();
                    if (m_tuser[0] !== e.status || m_tdata !== e.word
                            || m_tuser[1] !== e.word_ok || m_tlast !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected status %0b data %0d valid %0b last %0b",
                                     e.status, $signed(e.word), e.word_ok, e.last);
                            $display("          got status %0b data %0d valid %0b last %0b",
                                     m_tuser[0], $signed(m_tdata), m_tuser[1], m_tlast);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                model_stack_op(s_tuser, s_tdata[31:0], s_tdata[37:32]);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int n_rand;
        int r;
        int len;
        mismatches = 0;
        cycles = 0;
        plan_depth = 0;
        src_calm = 1'b0;
        sink_calm = 1'b0;

        // empty-stack cases, mostly errors, and reserved opcodes
        add_cmd(OP_POP, '0, '0);
        add_cmd(OP_PEEK_TOP, '0, '0);
        add_cmd(OP_PEEK_BOT, '0, '0);
        add_cmd(OP_POP_N, '0, '0);
        add_cmd(OP_POP_N, '0, 6'd1);
        add_cmd(OP_RSVD_5, 32'hFFFF_FFFF, 6'h3F);
        add_cmd(OP_RSVD_7, '0, '0);
        // extreme words, then peeks, pop-n bound errors and a drain
        add_cmd(OP_PUSH, 32'h8000_0000, 6'h3F);
        add_cmd(OP_PUSH, 32'h7FFF_FFFF, '0);
        add_cmd(OP_PUSH, 32'hFFFF_FFFF, '0);
        add_cmd(OP_PUSH, 32'h0000_0000, '0);
        add_cmd(OP_PEEK_TOP, '0, '0);
        add_cmd(OP_PEEK_BOT, '0, '0);
        add_cmd(OP_POP_N, '0, 6'h3F);
        add_cmd(OP_POP_N, '0, 6'd33);
        add_cmd(OP_POP_N, '0, 6'd5);
        add_cmd(OP_POP, '0, '0);
        add_cmd(OP_POP_N, '0, 6'd3);
        add_pause();

        // fill to full, overflow, peek, then drain in one pop-n and pop the empty stack
        n_rand = 0;
        while (plan_depth < DEPTH_DEF) begin
            add_cmd(OP_PUSH, $urandom, 6'($urandom_range(0, 63)));
            n_rand++;
        end
        add_cmd(OP_PUSH, $urandom, '0);
        add_cmd(OP_PUSH, $urandom, '0);
        add_cmd(OP_PEEK_TOP, '0, '0);
        add_cmd(OP_PEEK_BOT, '0, '0);
        add_cmd(OP_POP_N, '0, 6'd32);
        add_cmd(OP_POP, '0, '0);
        n_rand += 6;
        add_pause();

        while (n_rand < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                len = $urandom_range(1, 6);
                repeat (len) add_cmd(OP_PUSH, $urandom, 6'($urandom_range(0, 63)));
                n_rand += len;
            end else if (r < 50) begin
                add_cmd(OP_POP, $urandom, 6'($urandom_range(0, 63)));
                n_rand++;
            end else if (r < 60) begin
                add_cmd(OP_PEEK_TOP, $urandom, 6'($urandom_range(0, 63)));
                n_rand++;
            end else if (r < 68) begin
                add_cmd(OP_PEEK_BOT, $urandom, 6'($urandom_range(0, 63)));
                n_rand++;
            end else if (r < 85) begin
                add_cmd(OP_POP_N, $urandom, 6'($urandom_range(0, plan_depth)));
                n_rand++;
            end else if (r < 92) begin
                add_cmd(OP_POP_N, $urandom, 6'($urandom_range(0, 63)));
                n_rand++;
            end else if (r < 97) begin
                add_cmd(3'($urandom_range(OP_RSVD_5, OP_RSVD_7)), $urandom,
                        6'($urandom_range(0, 63)));
                n_rand++;
            end else begin
                add_pause();
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // sample between edges, once every update of the edge has settled
        @(negedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || draining
                || due_replies.size() != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && due_replies.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
